### src/mciir3_pkg.sv
`default_nettype none

package mciir3_pkg;

    localparam int CHANNELS    = 256;
    localparam int CH_W        = 8;
    localparam int CH_AW       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SAMPLE_W    = 32;
    localparam int COEF_W      = 24;
    localparam int LIMIT_W     = 31;
    localparam int NUM_COEF    = 6;
    localparam int PROD_W      = COEF_W + SAMPLE_W;
    localparam int PSUM_W      = PROD_W + 2;
    localparam int ACC_W       = PSUM_W + 1;
    localparam int FRAC_SHIFT  = 20;
    localparam int Y_W         = ACC_W - FRAC_SHIFT;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int TDATA_W     = CH_W + SAMPLE_W;
    localparam int CFG_AW      = 3;
    localparam int CFG_DW      = LIMIT_W;

    // coefficient slots
    localparam int COEF_OUT1 = 0;
    localparam int COEF_OUT2 = 1;
    localparam int COEF_OUT3 = 2;
    localparam int COEF_IN1  = 3;
    localparam int COEF_IN2  = 4;
    localparam int COEF_IN3  = 5;

    typedef enum logic [CFG_AW-1:0] {
        REG_OUT_LAG1 = 3'd0,
        REG_OUT_LAG2 = 3'd1,
        REG_OUT_LAG3 = 3'd2,
        REG_IN_LAG1  = 3'd3,
        REG_IN_LAG2  = 3'd4,
        REG_IN_LAG3  = 3'd5,
        REG_LIMIT    = 3'd6
    } cfg_reg_t;

    typedef logic signed [COEF_W-1:0]   coef_t;
    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [CH_W-1:0]            ch_t;
    typedef logic [CH_AW-1:0]           addr_t;
    typedef logic [LIMIT_W-1:0]         limit_t;

    localparam coef_t [NUM_COEF-1:0] COEF_RESET = {
        -24'sd67412,     // in lag 3
        24'sd23497,      // in lag 2
        24'sd125988,     // in lag 1
        24'sd388744,     // out lag 3
        -24'sd1519118,   // out lag 2
        24'sd2096876     // out lag 1
    };
    localparam limit_t LIMIT_RESET = 31'd655360000;

    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (FRAC_SHIFT - 1);

    typedef struct packed {
        sample_t out1;
        sample_t out2;
        sample_t out3;
        sample_t in1;
        sample_t in2;
        sample_t in3;
    } hist_row_t;

    typedef struct packed {
        coef_t [NUM_COEF-1:0] coef;
        limit_t               limit;
    } filt_cfg_t;

    typedef struct packed {
        ch_t     ch;
        sample_t sample;
        logic    in_range;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } q_head_t;

    typedef struct packed {
        logic  en;
        addr_t addr;
    } hist_rd_t;

    typedef struct packed {
        logic      en;
        addr_t     addr;
        hist_row_t row;
    } hist_wr_t;

    function automatic logic ch_in_range(input ch_t ch);
        return int'(ch) < CHANNELS;
    endfunction

    function automatic addr_t ch_to_addr(input ch_t ch);
        logic [CH_W+CH_AW-1:0] wide;
        wide = {{CH_AW{1'b0}}, ch};
        return wide[CH_AW-1:0];
    endfunction

endpackage

`default_nettype wire

### src/mciir3_front.sv
`default_nettype none

module mciir3_front import mciir3_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [TDATA_W-1:0] s_tdata,   // [7:0] channel, [39:8] sample
    input  logic               pop,
    output q_head_t            head
);

    item_t                 queue_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]     count_reg, count_next;
    item_t                 in_item;
    logic                  push;
    logic                  do_pop;

    assign s_tready = (count_reg != (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign push     = s_tvalid && s_tready;
    assign do_pop   = pop && head.valid;

    // classify at the door: range check travels with the item
    always_comb begin
        in_item.ch       = s_tdata[CH_W-1:0];
        in_item.sample   = s_tdata[CH_W +: SAMPLE_W];
        in_item.in_range = ch_in_range(s_tdata[CH_W-1:0]);
    end

    assign head.valid = (count_reg != '0);
    assign head.item  = queue_mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            queue_mem[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

### src/mciir3_hist_mem.sv
`default_nettype none

module mciir3_hist_mem import mciir3_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  hist_rd_t  rd,
    input  hist_wr_t  wr,
    output hist_row_t rd_row
);

    hist_row_t             hist_ram [CHANNELS];
    logic [CHANNELS-1:0]   valid_reg, valid_next;
    hist_row_t             rd_data_reg;
    logic                  rd_valid_reg;

    always_comb begin
        valid_next = valid_reg;
        if (wr.en) begin
            valid_next[wr.addr] = 1'b1;
        end
    end

    // read returns the old row when the same row is written in that cycle
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            hist_ram[wr.addr] <= wr.row;
        end
        if (rd.en) begin
            rd_data_reg <= hist_ram[rd.addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            if (rd.en) begin
                rd_valid_reg <= valid_reg[rd.addr];
            end
        end
    end

    // a row never written since reset reads as cleared history
    assign rd_row = rd_valid_reg ? rd_data_reg : '0;

endmodule

`default_nettype wire

### src/mciir3_back.sv
`default_nettype none

module mciir3_back import mciir3_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  filt_cfg_t          cfg,
    input  q_head_t            head,
    output logic               pop,
    output hist_rd_t           rd,
    input  hist_row_t          rd_row,
    output hist_wr_t           wr,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata    // [7:0] out_channel, [39:8] filtered
);

    q_head_t                   s1_reg, s1_next;
    q_head_t                   s2_reg, s3_reg, s4_reg;
    hist_row_t                 s2_row_reg, s3_row_reg, s4_row_reg;
    logic signed [PROD_W-1:0]  prod_reg [NUM_COEF];
    logic signed [PROD_W-1:0]  prod_next [NUM_COEF];
    logic signed [PSUM_W-1:0]  psum_out_reg, psum_in_reg;
    logic signed [PSUM_W-1:0]  psum_out_next, psum_in_next;
    logic signed [ACC_W-1:0]   acc;
    logic signed [Y_W-1:0]     y_reg;
    logic signed [Y_W-1:0]     lim_pos, lim_neg, y_sat;
    sample_t                   y_out;
    logic                      m_valid_reg, m_valid_next;
    ch_t                       m_ch_reg;
    sample_t                   m_filt_reg;
    logic                      advance;
    logic                      hazard;
    logic                      issue;

    function automatic logic same_row(input q_head_t st, input item_t it);
        return st.valid && st.item.in_range && (st.item.ch == it.ch);
    endfunction

    assign advance = !m_valid_reg || m_tready;

    // hold a channel back until its previous transaction has written its row
    assign hazard = head.item.in_range &&
                    (same_row(s1_reg, head.item) || same_row(s2_reg, head.item) ||
                     same_row(s3_reg, head.item) || same_row(s4_reg, head.item));
    assign issue  = head.valid && !hazard;
    assign pop    = advance && issue;

    assign rd.en   = advance;
    assign rd.addr = ch_to_addr(head.item.ch);

    always_comb begin
        s1_next = s1_reg;
        if (advance) begin
            s1_next.valid = issue;
            s1_next.item  = head.item;
        end
    end

    always_comb begin
        prod_next[COEF_OUT1] = $signed(cfg.coef[COEF_OUT1]) * $signed(rd_row.out1);
        prod_next[COEF_OUT2] = $signed(cfg.coef[COEF_OUT2]) * $signed(rd_row.out2);
        prod_next[COEF_OUT3] = $signed(cfg.coef[COEF_OUT3]) * $signed(rd_row.out3);
        prod_next[COEF_IN1]  = $signed(cfg.coef[COEF_IN1])  * $signed(rd_row.in1);
        prod_next[COEF_IN2]  = $signed(cfg.coef[COEF_IN2])  * $signed(rd_row.in2);
        prod_next[COEF_IN3]  = $signed(cfg.coef[COEF_IN3])  * $signed(rd_row.in3);
    end

    assign psum_out_next = PSUM_W'(prod_reg[COEF_OUT1]) + PSUM_W'(prod_reg[COEF_OUT2])
                         + PSUM_W'(prod_reg[COEF_OUT3]);
    assign psum_in_next  = PSUM_W'(prod_reg[COEF_IN1]) + PSUM_W'(prod_reg[COEF_IN2])
                         + PSUM_W'(prod_reg[COEF_IN3]);

    // round half up, then floor by dropping the fraction bits
    assign acc = ACC_W'(psum_out_reg) + ACC_W'(psum_in_reg) + ROUND_HALF;

    always_comb begin
        lim_pos = $signed(Y_W'(cfg.limit));
        lim_neg = -lim_pos;
        if (y_reg > lim_pos) begin
            y_sat = lim_pos;
        end else if (y_reg < lim_neg) begin
            y_sat = lim_neg;
        end else begin
            y_sat = y_reg;
        end
        y_out = y_sat[SAMPLE_W-1:0];
    end

    always_comb begin
        wr.en       = advance && s4_reg.valid && s4_reg.item.in_range;
        wr.addr     = ch_to_addr(s4_reg.item.ch);
        wr.row.out1 = y_out;
        wr.row.out2 = s4_row_reg.out1;
        wr.row.out3 = s4_row_reg.out2;
        wr.row.in1  = s4_reg.item.sample;
        wr.row.in2  = s4_row_reg.in1;
        wr.row.in3  = s4_row_reg.in2;
    end

    assign m_valid_next = advance ? s4_reg.valid : m_valid_reg;

    always_ff @(posedge aclk) begin
        if (advance) begin
            for (int i = 0; i < NUM_COEF; i++) begin
                prod_reg[i] <= prod_next[i];
            end
            s2_row_reg   <= rd_row;
            psum_out_reg <= psum_out_next;
            psum_in_reg  <= psum_in_next;
            s3_row_reg   <= s2_row_reg;
            y_reg        <= acc[ACC_W-1:FRAC_SHIFT];
            s4_row_reg   <= s3_row_reg;
            m_ch_reg     <= s4_reg.item.ch;
            m_filt_reg   <= s4_reg.item.in_range ? y_out : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_reg      <= '0;
            s2_reg      <= '0;
            s3_reg      <= '0;
            s4_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            s1_reg      <= s1_next;
            m_valid_reg <= m_valid_next;
            if (advance) begin
                s2_reg <= s1_reg;
                s3_reg <= s2_reg;
                s4_reg <= s3_reg;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_filt_reg, m_ch_reg};

endmodule

`default_nettype wire

### src/multichannel_iir3_saturating_filter_core.sv
//  channel   direction  width  contents (lowest bit first)
//  s_axis    in         40     channel[7:0], sample[39:8] (Q16.16)
//  m_axis    out        40     out_channel[7:0], filtered[39:8] (Q16.16)
//  cfg       in         3+31   register index, write data
//
//  One transaction per cycle while each channel differs from the four issued
//  before it and m_tready does not stall the output; the history row read,
//  multiply, two add levels and clamp are registered in turn, and a channel
//  that repeats while its previous transaction is in them waits for its row
//  write-back. m_tvalid and m_tdata are registered behind the clamp.
//  Reset clears histories at once through per-channel valid bits.
//  A four-entry queue keeps s_tready independent of m_tready; a stall on the
//  output freezes the whole back pipeline.
`default_nettype none

module multichannel_iir3_saturating_filter_core import mciir3_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [CFG_AW-1:0]  cfg_addr,
    input  logic [CFG_DW-1:0]  cfg_wdata,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [TDATA_W-1:0] s_tdata,   // [7:0] channel, [39:8] sample
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata    // [7:0] out_channel, [39:8] filtered
);

    coef_t [NUM_COEF-1:0] coef_reg, coef_next;
    limit_t               limit_reg, limit_next;
    filt_cfg_t            cfg;
    q_head_t              head;
    logic                 pop;
    hist_rd_t             hist_rd;
    hist_wr_t             hist_wr;
    hist_row_t            hist_row;

    always_comb begin
        coef_next  = coef_reg;
        limit_next = limit_reg;
        if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_OUT_LAG1: coef_next[COEF_OUT1] = cfg_wdata[COEF_W-1:0];
                REG_OUT_LAG2: coef_next[COEF_OUT2] = cfg_wdata[COEF_W-1:0];
                REG_OUT_LAG3: coef_next[COEF_OUT3] = cfg_wdata[COEF_W-1:0];
                REG_IN_LAG1:  coef_next[COEF_IN1]  = cfg_wdata[COEF_W-1:0];
                REG_IN_LAG2:  coef_next[COEF_IN2]  = cfg_wdata[COEF_W-1:0];
                REG_IN_LAG3:  coef_next[COEF_IN3]  = cfg_wdata[COEF_W-1:0];
                REG_LIMIT:    limit_next           = cfg_wdata[LIMIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg  <= COEF_RESET;
            limit_reg <= LIMIT_RESET;
        end else begin
            coef_reg  <= coef_next;
            limit_reg <= limit_next;
        end
    end

    assign cfg.coef  = coef_reg;
    assign cfg.limit = limit_reg;

    mciir3_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .pop      (pop),
        .head     (head)
    );

    mciir3_hist_mem u_hist_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd      (hist_rd),
        .wr      (hist_wr),
        .rd_row  (hist_row)
    );

    mciir3_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .head     (head),
        .pop      (pop),
        .rd       (hist_rd),
        .rd_row   (hist_row),
        .wr       (hist_wr),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

### src/mciir3_checker.sv
`default_nettype none

module mciir3_checker import mciir3_pkg::*; (
    input logic               aclk,
    input logic               aresetn,
    input logic               cfg_wr_en,
    input logic [CFG_AW-1:0]  cfg_addr,
    input logic [CFG_DW-1:0]  cfg_wdata,
    input logic               s_tready,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [TDATA_W-1:0] m_tdata
);

    limit_t limit_shadow_reg;

    // track the clamp limit as seen on the configuration port
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_shadow_reg <= LIMIT_RESET;
        end else if (cfg_wr_en && (cfg_addr == REG_LIMIT)) begin
            limit_shadow_reg <= cfg_wdata[LIMIT_W-1:0];
        end
    end

    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("output valid or input stalled right after reset");

    a_out_valid_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result transaction withdrawn while stalled");

    a_out_data_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result payload changed while stalled");

    a_clamp_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |->
            ($signed(m_tdata[CH_W +: SAMPLE_W]) <= $signed({1'b0, limit_shadow_reg})) &&
            ($signed(m_tdata[CH_W +: SAMPLE_W]) >= -$signed({1'b0, limit_shadow_reg})))
        else $error("filtered value outside the output limit");

endmodule

bind multichannel_iir3_saturating_filter_core mciir3_checker u_checker (.*);

`default_nettype wire
